/* src/agkf_pkg.sv */
// Package for the angle / gyro-bias Kalman filter: word types, sequencer
// step codes, widths and the 32-bit saturation helper. No dependencies.
`timescale 1ns / 1ps
package agkf_pkg;

   typedef struct packed {
      logic signed [31:0] angle_meas;
      logic signed [31:0] gyro_rate;
   } req_word_type;

   typedef struct packed {
      logic signed [31:0] angle_est;
      logic signed [31:0] rate_est;
   } rsp_word_type;

   // Register indexes of the configuration port.
   localparam logic [2:0] CSR_NOISE_ANGLE = 3'd0;
   localparam logic [2:0] CSR_NOISE_BIAS  = 3'd1;
   localparam logic [2:0] CSR_NOISE_MEAS  = 3'd2;
   localparam logic [2:0] CSR_PERIOD      = 3'd3;

   // Multiply steps of the sequencer, in the order they run.
   localparam logic [3:0] OP_ANG   = 4'd0;
   localparam logic [3:0] OP_DRIFT = 4'd1;
   localparam logic [3:0] OP_QA    = 4'd2;
   localparam logic [3:0] OP_SUM   = 4'd3;
   localparam logic [3:0] OP_QB    = 4'd4;
   localparam logic [3:0] OP_K1P00 = 4'd5;
   localparam logic [3:0] OP_K1P01 = 4'd6;
   localparam logic [3:0] OP_K0P01 = 4'd7;
   localparam logic [3:0] OP_K0P00 = 4'd8;
   localparam logic [3:0] OP_K0ERR = 4'd9;
   localparam logic [3:0] OP_K1ERR = 4'd10;

   localparam int MUL_STEPS = 32;
   localparam int DIV_STEPS = 62;

   localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;

   function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
      logic signed [31:0] r;
      if (v > 40'sh00_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -40'sh00_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

/* src/angle_gyro_kalman_fusion.sv */
// Top level of the two-state angle / gyro-bias Kalman filter with a
// bit-serial multiplier and divider. Depends on agkf_pkg.
`timescale 1ns / 1ps
//
//   channel   direction  handshake            word
//   req_      in         req_valid/req_stall  angle_meas, gyro_rate
//   rsp_      out        rsp_valid/rsp_stall  angle_est, rate_est
//   csr_      in         csr_valid/csr_ready  csr_index, csr_data
//
// When the correction runs, an item takes eleven products and two gain
// divisions; when the innovation variance is not positive, it takes the
// five prediction products only. They run on the shared shift-add
// multiplier (one bit of the multiplier per cycle) and the restoring
// divider (one quotient bit per cycle, one division per gain).
// Reset is synchronous and restores configuration, estimates and covariance.
// A finished word waits in the output register while the next item is
// taken; the output step holds while a word waits and rsp_stall is high.
module angle_gyro_kalman_fusion
   import agkf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_data,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [2:0]   csr_index,
   input  logic [31:0]  csr_data
);

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_MLOAD = 9'b000000010,
      ST_MUL   = 9'b000000100,
      ST_MWB   = 9'b000001000,
      ST_CHECK = 9'b000010000,
      ST_DLOAD = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_DWB   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // Configuration registers.
   logic [31:0] qa_ff, qb_ff, rn_ff;
   logic [30:0] dt_ff;

   // Filter state.
   logic signed [31:0] angle_ff, angle_in;
   logic signed [31:0] bias_ff, bias_in;
   logic signed [31:0] aa_ff, aa_in, ab_ff, ab_in, ba_ff, ba_in, bb_ff, bb_in;

   // Sequencer control.
   logic [3:0] op_ff, op_in;
   logic [5:0] cnt_ff, cnt_in;
   logic       dsel_ff, dsel_in;
   logic       rsp_valid_ff, rsp_valid_in;

   // Datapath registers.
   logic signed [31:0] meas_ff, gyro_ff;
   logic signed [37:0] drift_ff, tq_ff;
   logic signed [31:0] err_ff, k0_ff, k1_ff;
   logic signed [33:0] e_ff;
   logic [33:0]        amag_ff;
   logic               mneg_ff, dneg_ff;
   logic [66:0]        prod_ff;
   logic [61:0]        num_ff, quo_ff;
   logic [33:0]        rem_ff;
   rsp_word_type       rsp_data_ff;

   logic signed [31:0] rate_cur;
   logic signed [33:0] a_sel, e_cur;
   logic signed [31:0] b_sel, p_sel;
   logic [33:0]        a_mag;
   logic [31:0]        b_mag, p_mag;
   logic [35:0]        mul_sum;
   logic [66:0]        prod_rnd;
   logic signed [37:0] rv;
   logic signed [39:0] rvx;
   logic [34:0]        div_r2;
   logic               div_ge;
   logic signed [31:0] k_sat;

   assign csr_ready = 1'b1;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign rate_cur = sat32(40'(gyro_ff) - 40'(bias_ff));
   assign e_cur    = signed'({2'b00, rn_ff}) + 34'(aa_ff);

   // Operand selection for the shared multiplier.
   always_comb begin
      a_sel = 34'(aa_ff);
      b_sel = k0_ff;
      unique case (op_ff)
         OP_ANG: begin
            a_sel = 34'(rate_cur);
            b_sel = signed'({1'b0, dt_ff});
         end
         OP_DRIFT: begin
            a_sel = 34'(bb_ff);
            b_sel = signed'({1'b0, dt_ff});
         end
         OP_QA: begin
            a_sel = signed'({2'b00, qa_ff});
            b_sel = signed'({1'b0, dt_ff});
         end
         OP_SUM: begin
            a_sel = 34'(ab_ff) + 34'(ba_ff);
            b_sel = signed'({1'b0, dt_ff});
         end
         OP_QB: begin
            a_sel = signed'({2'b00, qb_ff});
            b_sel = signed'({1'b0, dt_ff});
         end
         OP_K1P00: begin
            a_sel = 34'(aa_ff);
            b_sel = k1_ff;
         end
         OP_K1P01: begin
            a_sel = 34'(ab_ff);
            b_sel = k1_ff;
         end
         OP_K0P01: begin
            a_sel = 34'(ab_ff);
            b_sel = k0_ff;
         end
         OP_K0P00: begin
            a_sel = 34'(aa_ff);
            b_sel = k0_ff;
         end
         OP_K0ERR: begin
            a_sel = 34'(err_ff);
            b_sel = k0_ff;
         end
         OP_K1ERR: begin
            a_sel = 34'(err_ff);
            b_sel = k1_ff;
         end
         default: begin
            a_sel = 34'(aa_ff);
            b_sel = k0_ff;
         end
      endcase
   end

   assign a_mag = a_sel[33] ? (~a_sel + 34'd1) : a_sel;
   assign b_mag = b_sel[31] ? (~b_sel + 32'd1) : b_sel;

   // One multiplier bit per cycle: add the multiplicand into the upper half
   // when the low bit is set, then shift the whole product right.
   assign mul_sum = {1'b0, prod_ff[66:32]} + (prod_ff[0] ? {2'b00, amag_ff} : 36'd0);

   // Round half away from zero on the magnitude, then restore the sign.
   assign prod_rnd = prod_ff + 67'(1 << 29);
   assign rv       = mneg_ff ? -signed'({1'b0, prod_rnd[66:30]})
                             : signed'({1'b0, prod_rnd[66:30]});
   assign rvx      = 40'(rv);

   // Restoring division, one quotient bit per cycle.
   assign p_sel  = dsel_ff ? ba_ff : aa_ff;
   assign p_mag  = p_sel[31] ? (~p_sel + 32'd1) : p_sel;
   assign div_r2 = {rem_ff, num_ff[61]};
   assign div_ge = (div_r2 >= {1'b0, e_ff});

   always_comb begin
      if (quo_ff >= 62'(64'h8000_0000)) begin
         k_sat = dneg_ff ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         k_sat = dneg_ff ? -signed'(quo_ff[31:0]) : signed'(quo_ff[31:0]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      cnt_in       = cnt_ff;
      dsel_in      = dsel_ff;
      angle_in     = angle_ff;
      bias_in      = bias_ff;
      aa_in        = aa_ff;
      ab_in        = ab_ff;
      ba_in        = ba_ff;
      bb_in        = bb_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = OP_ANG;
               state_in = ST_MLOAD;
            end
         end
         ST_MLOAD: begin
            cnt_in   = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(MUL_STEPS - 1)) begin
               state_in = ST_MWB;
            end
         end
         ST_MWB: begin
            unique case (op_ff)
               OP_ANG:   angle_in = sat32(40'(angle_ff) + rvx);
               OP_DRIFT: ;
               OP_QA:    ;
               OP_SUM: begin
                  aa_in = sat32(40'(aa_ff) + 40'(tq_ff) - rvx);
                  ab_in = sat32(40'(ab_ff) - 40'(drift_ff));
                  ba_in = sat32(40'(ba_ff) - 40'(drift_ff));
               end
               OP_QB:    bb_in    = sat32(40'(bb_ff) + rvx);
               OP_K1P00: ba_in    = sat32(40'(ba_ff) - rvx);
               OP_K1P01: bb_in    = sat32(40'(bb_ff) - rvx);
               OP_K0P01: ab_in    = sat32(40'(ab_ff) - rvx);
               OP_K0P00: aa_in    = sat32(40'(aa_ff) - rvx);
               OP_K0ERR: angle_in = sat32(40'(angle_ff) + rvx);
               OP_K1ERR: bias_in  = sat32(40'(bias_ff) + rvx);
               default:  ;
            endcase
            if (op_ff == OP_QB) begin
               state_in = ST_CHECK;
            end else if (op_ff == OP_K1ERR) begin
               state_in = ST_OUT;
            end else begin
               op_in    = op_ff + 4'd1;
               state_in = ST_MLOAD;
            end
         end
         ST_CHECK: begin
            dsel_in = 1'b0;
            // A variance that is not positive skips the correction.
            if (!e_cur[33] && (e_cur != '0)) begin
               state_in = ST_DLOAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DLOAD: begin
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(DIV_STEPS - 1)) begin
               state_in = ST_DWB;
            end
         end
         ST_DWB: begin
            if (!dsel_ff) begin
               dsel_in  = 1'b1;
               state_in = ST_DLOAD;
            end else begin
               op_in    = OP_K1P00;
               state_in = ST_MLOAD;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= OP_ANG;
         cnt_ff       <= '0;
         dsel_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         qa_ff        <= 32'd1074;
         qb_ff        <= 32'd107374;
         rn_ff        <= 32'd536870912;
         dt_ff        <= 31'd2147484;
         angle_ff     <= '0;
         bias_ff      <= '0;
         aa_ff        <= Q30_ONE;
         ab_ff        <= '0;
         ba_ff        <= '0;
         bb_ff        <= Q30_ONE;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         cnt_ff       <= cnt_in;
         dsel_ff      <= dsel_in;
         rsp_valid_ff <= rsp_valid_in;
         angle_ff     <= angle_in;
         bias_ff      <= bias_in;
         aa_ff        <= aa_in;
         ab_ff        <= ab_in;
         ba_ff        <= ba_in;
         bb_ff        <= bb_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_NOISE_ANGLE: qa_ff <= csr_data;
               CSR_NOISE_BIAS:  qb_ff <= csr_data;
               CSR_NOISE_MEAS:  rn_ff <= csr_data;
               CSR_PERIOD:      dt_ff <= csr_data[30:0];
               default:         ;
            endcase
         end
      end
   end

   // Datapath registers carry no reset.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_valid) begin
         meas_ff <= req_data.angle_meas;
         gyro_ff <= req_data.gyro_rate;
      end
      if (state_ff == ST_MLOAD) begin
         amag_ff <= a_mag;
         mneg_ff <= a_sel[33] ^ b_sel[31];
         prod_ff <= {35'd0, b_mag};
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= {mul_sum, prod_ff[31:1]};
      end
      if (state_ff == ST_MWB) begin
         if (op_ff == OP_DRIFT) begin
            drift_ff <= rv;
         end
         if (op_ff == OP_QA) begin
            tq_ff <= rv;
         end
      end
      if (state_ff == ST_CHECK) begin
         e_ff   <= e_cur;
         err_ff <= sat32(40'(meas_ff) - 40'(angle_ff));
      end
      if (state_ff == ST_DLOAD) begin
         num_ff  <= {p_mag, 30'd0};
         rem_ff  <= '0;
         quo_ff  <= '0;
         dneg_ff <= p_sel[31];
      end
      if (state_ff == ST_DIV) begin
         num_ff <= {num_ff[60:0], 1'b0};
         rem_ff <= div_ge ? 34'(div_r2 - {1'b0, e_ff}) : div_r2[33:0];
         quo_ff <= {quo_ff[60:0], div_ge};
      end
      if (state_ff == ST_DWB) begin
         if (!dsel_ff) begin
            k0_ff <= k_sat;
         end else begin
            k1_ff <= k_sat;
         end
      end
      if (state_ff == ST_OUT && (!rsp_valid_ff || !rsp_stall)) begin
         rsp_data_ff.angle_est <= angle_ff;
         rsp_data_ff.rate_est  <= rate_cur;
      end
   end

`ifndef NO_ASSERTIONS
   // An accepted item always starts the first product next.
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> state_ff == ST_MLOAD)
      else $error("accepted item did not start the sequencer");

   // The multiply counter never runs past its bit count.
   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL |-> cnt_ff < 6'(MUL_STEPS))
      else $error("multiply counter out of range");

   // Division only runs with a positive divisor.
   a_div_pos: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> !e_ff[33] && e_ff != '0)
      else $error("division with a divisor that is not positive");

   // A multiply is only loaded for a valid step.
   a_op_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MLOAD |-> op_ff <= OP_K1ERR)
      else $error("sequencer step out of range");
`endif

endmodule

/* tb/angle_gyro_kalman_fusion_tb.sv */
// Self-checking testbench for the angle / gyro-bias Kalman filter: drives sample words,
// predicts the fused angle and corrected rate, and compares every result word.
// Depends on agkf_pkg and angle_gyro_kalman_fusion.
`timescale 1ns / 1ps
module angle_gyro_kalman_fusion_tb;
   import agkf_pkg::*;

   localparam int LATENCY = 520;
   localparam longint LIMIT = 4000000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_data;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_data;
   logic         csr_valid;
   logic         csr_ready;
   logic [2:0]   csr_index;
   logic [31:0]  csr_data;

   angle_gyro_kalman_fusion dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Free-running clock, 10 ns period.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Filter state and registers as the testbench believes them to be.
   logic [31:0] noise_angle, noise_bias, noise_meas;
   logic [30:0] period;
   longint angle_q, bias_q, p_aa, p_ab, p_ba, p_bb;

   req_word_type  sample_queue[$];   // samples waiting to be offered
   rsp_word_type  fused_queue[$];    // predicted result words, oldest first

   int  error_count;
   int  send_idle_pct, recv_stall_pct;
   bit  hold_off;                    // receiver forced to stall for a long stretch
   int  hold_cycles;
   bit  hold_request;
   bit  req_taken;                   // the word on offer was taken at the last rising edge
   longint cycle_count;

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // Divide by 2^30 with rounding half away from zero.
   function automatic longint round_q30(longint v);
      longint half;
      half = 64'sd1 << 29;
      if (v >= 0) return (v + half) / 64'sd1073741824;
      return -((-v + half) / 64'sd1073741824);
   endfunction

   function automatic void filter_reset();
      noise_angle = 32'd1074;
      noise_bias = 32'd107374;
      noise_meas = 32'd536870912;
      period = 31'd2147484;
      angle_q = 0;
      bias_q = 0;
      p_aa = 64'sd1073741824;
      p_ab = 0;
      p_ba = 0;
      p_bb = 64'sd1073741824;
   endfunction

   // One filter step: predict, then correct when the innovation variance is positive.
   function automatic rsp_word_type fuse_sample(req_word_type s);
      longint meas, gyro, dt, rate, drift, e, err, k0, k1;
      longint n00, n01, n10, n11;
      rsp_word_type w;
      meas = longint'(s.angle_meas);
      gyro = longint'(s.gyro_rate);
      dt = longint'({33'd0, period});
      rate = clamp32(gyro - bias_q);
      angle_q = clamp32(angle_q + round_q30(rate * dt));
      drift = round_q30(p_bb * dt);
      n00 = clamp32(p_aa + round_q30(longint'({32'd0, noise_angle}) * dt)
                    - round_q30((p_ab + p_ba) * dt));
      n01 = clamp32(p_ab - drift);
      n10 = clamp32(p_ba - drift);
      n11 = clamp32(p_bb + round_q30(longint'({32'd0, noise_bias}) * dt));
      p_aa = n00;
      p_ab = n01;
      p_ba = n10;
      p_bb = n11;
      e = longint'({32'd0, noise_meas}) + n00;
      if (e > 0) begin
         err = clamp32(meas - angle_q);
         k0 = clamp32((n00 * 64'sd1073741824) / e);
         k1 = clamp32((n10 * 64'sd1073741824) / e);
         p_aa = clamp32(n00 - round_q30(k0 * n00));
         p_ab = clamp32(n01 - round_q30(k0 * n01));
         p_ba = clamp32(n10 - round_q30(k1 * n00));
         p_bb = clamp32(n11 - round_q30(k1 * n01));
         angle_q = clamp32(angle_q + round_q30(k0 * err));
         bias_q = clamp32(bias_q + round_q30(k1 * err));
      end
      rate = clamp32(gyro - bias_q);
      w.angle_est = angle_q[31:0];
      w.rate_est = rate[31:0];
      return w;
   endfunction

   // Driver: offers queued samples at the falling edge. A word that is not yet
   // taken stays put; the next word is loaded only after the accepting edge.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) begin
            fused_queue.push_back(fuse_sample(req_data));
            void'(sample_queue.pop_front());
         end
         if (!req_valid || req_taken) begin
            if (sample_queue.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= sample_queue[0];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall, including a long hold-off counted here.
   always @(negedge clock) begin
      if (hold_request && !hold_off) begin
         hold_off <= 1'b1;
         hold_cycles <= 3000;
         rsp_stall <= 1'b1;
      end else if (hold_off) begin
         hold_cycles <= hold_cycles - 1;
         if (hold_cycles <= 1) begin
            hold_off <= 1'b0;
         end
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      end
   end

   // Monitor: notes each accepted sample and compares every accepted result
   // word with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (fused_queue.size() == 0) begin
            $error("unexpected word: angle_est %0d rate_est %0d",
                   rsp_data.angle_est, rsp_data.rate_est);
            error_count = error_count + 1;
         end else begin
            want = fused_queue.pop_front();
            if (rsp_data.angle_est !== want.angle_est) begin
               $error("angle_est expected %0d actual %0d", want.angle_est, rsp_data.angle_est);
               error_count = error_count + 1;
            end
            if (rsp_data.rate_est !== want.rate_est) begin
               $error("rate_est expected %0d actual %0d", want.rate_est, rsp_data.rate_est);
               error_count = error_count + 1;
            end
         end
      end
   end

   // Timeout guard.
   always @(posedge clock) begin
      if (cycle_count > LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Waits until every queued sample has been taken and every result word has arrived.
   task automatic drain();
      while (sample_queue.size() > 0 || req_valid || fused_queue.size() > 0) begin
         @(posedge clock);
      end
   endtask

   // Writes one register at a falling edge, holding until the block takes it.
   // The block is idle here, so the predictor copy is updated at once.
   task automatic write_reg(logic [2:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      @(negedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_NOISE_ANGLE: noise_angle = value;
         CSR_NOISE_BIAS:  noise_bias = value;
         CSR_NOISE_MEAS:  noise_meas = value;
         CSR_PERIOD:      period = value[30:0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] wild32();
      logic [31:0] v;
      case ($urandom_range(5, 0))
         0: v = 32'h7FFF_FFFF;
         1: v = 32'h8000_0000;
         2: v = $urandom_range(200, 0) - 100;
         default: v = $urandom();
      endcase
      return v;
   endfunction

   // A sample of a slowly turning body, with noise on the gyro rate and the accelerometer angle.
   function automatic req_word_type motion_sample(int step, int slope);
      req_word_type s;
      s.gyro_rate = slope + $signed($urandom_range(8191, 0)) - 4096;
      s.angle_meas = slope * step / 500 + $signed($urandom_range(131071, 0)) - 65536;
      return s;
   endfunction

   // Runs one batch of samples at the given idle and stall rates, then drains.
   task automatic run_batch(int n, int idle_pct, int stall_pct, bit wild);
      int slope;
      req_word_type s;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      slope = $signed($urandom_range(2000000, 0)) - 1000000;
      for (int i = 0; i < n; i++) begin
         if (wild && $urandom_range(3, 0) == 0) begin
            s.angle_meas = wild32();
            s.gyro_rate = wild32();
         end else begin
            s = motion_sample(i, slope);
         end
         sample_queue.push_back(s);
      end
      drain();
   endtask

   initial begin
      req_word_type s;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      hold_off = 1'b0;
      hold_cycles = 0;
      hold_request = 1'b0;
      cycle_count = 0;
      error_count = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      filter_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part at reset settings: field extremes, both signs, zero.
      s.angle_meas = 32'sh7FFF_FFFF; s.gyro_rate = 32'sh7FFF_FFFF; sample_queue.push_back(s);
      s.angle_meas = 32'sh8000_0000; s.gyro_rate = 32'sh8000_0000; sample_queue.push_back(s);
      s.angle_meas = 32'sh7FFF_FFFF; s.gyro_rate = 32'sh8000_0000; sample_queue.push_back(s);
      s.angle_meas = 32'sh8000_0000; s.gyro_rate = 32'sh7FFF_FFFF; sample_queue.push_back(s);
      s.angle_meas = '0; s.gyro_rate = '0; sample_queue.push_back(s);
      s.angle_meas = -1; s.gyro_rate = 1; sample_queue.push_back(s);
      s.angle_meas = 32'sh5555_5555; s.gyro_rate = 32'shAAAA_AAAA; sample_queue.push_back(s);
      s.angle_meas = 32'shAAAA_AAAA; s.gyro_rate = 32'sh5555_5555; sample_queue.push_back(s);
      drain();

      // Zero measurement noise still leaves a positive variance; zero period
      // freezes the prediction; a period of 1.0 (Q30) with full-scale rates saturates.
      write_reg(CSR_NOISE_MEAS, 32'd0);
      write_reg(CSR_PERIOD, 32'd0);
      s.angle_meas = 32'sh0010_0000; s.gyro_rate = 32'sh0100_0000; sample_queue.push_back(s);
      s.angle_meas = 32'sh8000_0000; s.gyro_rate = 32'sh7FFF_FFFF; sample_queue.push_back(s);
      drain();
      write_reg(CSR_PERIOD, 32'h4000_0000);
      write_reg(CSR_NOISE_ANGLE, 32'hFFFF_FFFF);
      write_reg(CSR_NOISE_BIAS, 32'hFFFF_FFFF);
      for (int i = 0; i < 4; i++) begin
         s.angle_meas = (i & 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         s.gyro_rate = (i & 1) ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
         sample_queue.push_back(s);
      end
      drain();

      // Tiny measurement noise with a period that drives the angle covariance
      // strongly negative, so the innovation variance turns non-positive and
      // only the prediction runs.
      write_reg(CSR_NOISE_ANGLE, 32'd0);
      write_reg(CSR_NOISE_MEAS, 32'd1);
      write_reg(CSR_PERIOD, 32'h7FFF_FFFF);
      for (int i = 0; i < 6; i++) begin
         s.angle_meas = wild32();
         s.gyro_rate = wild32();
         sample_queue.push_back(s);
      end
      drain();
      // Every result word has arrived here; the wait adds idle time before the writes.
      repeat (LATENCY) @(posedge clock);

      // Out-of-range register indexes are ignored by the block.
      write_reg(3'd4, 32'hDEAD_BEEF);
      write_reg(3'd7, 32'h1234_5678);

      // Back to sensible settings; the filter keeps its state across writes.
      write_reg(CSR_NOISE_ANGLE, 32'd1074);
      write_reg(CSR_NOISE_BIAS, 32'd107374);
      write_reg(CSR_NOISE_MEAS, 32'd536870912);
      write_reg(CSR_PERIOD, 32'd2147484);
      run_batch(100, 0, 0, 1'b0);
      run_batch(90, 62, 0, 1'b1);

      // Receiver holds off for a long stretch while samples keep coming.
      for (int i = 0; i < 12; i++) sample_queue.push_back(motion_sample(i, 300000));
      recv_stall_pct = 0;
      send_idle_pct = 0;
      hold_request = 1'b1;
      @(posedge clock);
      hold_request = 1'b0;
      drain();

      write_reg(CSR_NOISE_MEAS, $urandom_range(32'h7FFF_FFFF, 1));
      write_reg(CSR_PERIOD, $urandom_range(32'h0100_0000, 1));
      write_reg(CSR_NOISE_ANGLE, $urandom());
      write_reg(CSR_NOISE_BIAS, $urandom_range(32'h0010_0000, 0));
      run_batch(90, 0, 62, 1'b1);
      run_batch(90, 25, 25, 1'b0);

      write_reg(CSR_NOISE_MEAS, 32'hFFFF_FFFF);
      write_reg(CSR_PERIOD, 32'd1);
      run_batch(80, 0, 0, 1'b1);

      write_reg(CSR_NOISE_ANGLE, 32'd1074);
      write_reg(CSR_NOISE_BIAS, 32'd107374);
      write_reg(CSR_NOISE_MEAS, 32'd536870912);
      write_reg(CSR_PERIOD, 32'd2147484);
      run_batch(100, 62, 62, 1'b0);

      repeat (LATENCY) @(posedge clock);
      if (error_count == 0 && fused_queue.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
